### sv/tavc_pkg.sv
`timescale 1ns / 1ps

package tavc_pkg;

    localparam int VELOCITY_BITS = 32;
    localparam int GAIN_W        = 16;
    localparam int LIMIT_W       = 31;
    localparam int TICK_W        = 16;
    localparam int DT_FRAC_BITS  = 20;

    localparam logic [TICK_W-1:0] TICK_LIMIT = TICK_W'(20971);

    localparam int PS_W   = VELOCITY_BITS + 1;
    localparam int FF_W   = VELOCITY_BITS + GAIN_W;
    localparam int ACC_W  = LIMIT_W + TICK_W;
    localparam int MAXD_W = ACC_W - DT_FRAC_BITS;
    localparam int SUM_W0 = ((PS_W + 8 > FF_W) ? PS_W + 8 : FF_W) + 1;
    localparam int SUM_W  = (SUM_W0 > LIMIT_W + 9) ? SUM_W0 : LIMIT_W + 9;
    localparam int SLEW_W = (VELOCITY_BITS + 2 > MAXD_W + 2) ? VELOCITY_BITS + 2 : MAXD_W + 2;

    localparam int IN_RAW_W  = 6 * VELOCITY_BITS + TICK_W;
    localparam int IN_W      = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_RAW_W = 2 * VELOCITY_BITS;
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0]
    {
        REG_FF_GAIN   = 3'd0,
        REG_VMAX_PAN  = 3'd1,
        REG_VMAX_TILT = 3'd2,
        REG_AMAX_PAN  = 3'd3,
        REG_AMAX_TILT = 3'd4
    } reg_idx_t;

    typedef logic signed [VELOCITY_BITS-1:0] vel_t;

    typedef struct packed
    {
        logic [GAIN_W-1:0]  gain;
        logic [LIMIT_W-1:0] vmax;
        logic [LIMIT_W-1:0] amax;
    } lane_cfg_t;

    typedef struct packed
    {
        logic ld1;
        logic ld2;
        logic upd;
    } lane_ctrl_t;

endpackage

### sv/tavc_cfg.sv
`timescale 1ns / 1ps

module tavc_cfg
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tavc_pkg::ADDR_W-1:0]  paddr,
    input  logic [tavc_pkg::DATA_W-1:0]  pwdata,
    output logic [tavc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output tavc_pkg::lane_cfg_t          cfg_pan,
    output tavc_pkg::lane_cfg_t          cfg_tilt
);

    logic [tavc_pkg::GAIN_W-1:0]  gain_reg;
    logic [tavc_pkg::LIMIT_W-1:0] vmax_pan_reg;
    logic [tavc_pkg::LIMIT_W-1:0] vmax_tilt_reg;
    logic [tavc_pkg::LIMIT_W-1:0] amax_pan_reg;
    logic [tavc_pkg::LIMIT_W-1:0] amax_tilt_reg;
    tavc_pkg::reg_idx_t           idx;
    logic                         wr;

    assign pready = 1'b1;
    assign idx    = tavc_pkg::reg_idx_t'(paddr[tavc_pkg::ADDR_W-1:2]);
    assign wr     = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= tavc_pkg::GAIN_W'(256);
            vmax_pan_reg  <= '0;
            vmax_tilt_reg <= '0;
            amax_pan_reg  <= '0;
            amax_tilt_reg <= '0;
        end
        else if (wr)
        begin
            case (idx)
                tavc_pkg::REG_FF_GAIN:   gain_reg      <= pwdata[tavc_pkg::GAIN_W-1:0];
                tavc_pkg::REG_VMAX_PAN:  vmax_pan_reg  <= pwdata[tavc_pkg::LIMIT_W-1:0];
                tavc_pkg::REG_VMAX_TILT: vmax_tilt_reg <= pwdata[tavc_pkg::LIMIT_W-1:0];
                tavc_pkg::REG_AMAX_PAN:  amax_pan_reg  <= pwdata[tavc_pkg::LIMIT_W-1:0];
                tavc_pkg::REG_AMAX_TILT: amax_tilt_reg <= pwdata[tavc_pkg::LIMIT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            tavc_pkg::REG_FF_GAIN:   prdata = tavc_pkg::DATA_W'($signed(gain_reg));
            tavc_pkg::REG_VMAX_PAN:  prdata = tavc_pkg::DATA_W'(vmax_pan_reg);
            tavc_pkg::REG_VMAX_TILT: prdata = tavc_pkg::DATA_W'(vmax_tilt_reg);
            tavc_pkg::REG_AMAX_PAN:  prdata = tavc_pkg::DATA_W'(amax_pan_reg);
            tavc_pkg::REG_AMAX_TILT: prdata = tavc_pkg::DATA_W'(amax_tilt_reg);
            default:                 prdata = '0;
        endcase
    end

    assign cfg_pan.gain  = gain_reg;
    assign cfg_pan.vmax  = vmax_pan_reg;
    assign cfg_pan.amax  = amax_pan_reg;
    assign cfg_tilt.gain = gain_reg;
    assign cfg_tilt.vmax = vmax_tilt_reg;
    assign cfg_tilt.amax = amax_tilt_reg;

endmodule

### sv/tavc_lane.sv
`timescale 1ns / 1ps

module tavc_lane
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  tavc_pkg::lane_ctrl_t              ctrl,
    input  tavc_pkg::lane_cfg_t               cfg,
    input  tavc_pkg::vel_t                    pos,
    input  tavc_pkg::vel_t                    stab,
    input  tavc_pkg::vel_t                    ff,
    input  logic [tavc_pkg::TICK_W-1:0]       tick,
    output tavc_pkg::vel_t                    held
);

    logic signed [tavc_pkg::PS_W-1:0]   pos_stab_next;
    logic signed [tavc_pkg::PS_W-1:0]   pos_stab_reg;
    logic signed [tavc_pkg::FF_W-1:0]   ff_prod_next;
    logic signed [tavc_pkg::FF_W-1:0]   ff_prod_reg;
    logic [tavc_pkg::ACC_W-1:0]         acc_prod;
    logic [tavc_pkg::MAXD_W-1:0]        maxd_next;
    logic [tavc_pkg::MAXD_W-1:0]        maxd1_reg;
    logic [tavc_pkg::MAXD_W-1:0]        maxd2_reg;

    logic signed [tavc_pkg::SUM_W-1:0]  sum;
    logic signed [tavc_pkg::SUM_W-1:0]  lim_scaled;
    logic signed [tavc_pkg::SUM_W-1:0]  lim_wide;
    logic signed [tavc_pkg::SUM_W-1:0]  rnd;
    logic signed [tavc_pkg::SUM_W-1:0]  clamped;
    logic signed [tavc_pkg::SUM_W-1:0]  vtop;
    logic signed [tavc_pkg::SUM_W-1:0]  vbot;
    logic signed [tavc_pkg::SUM_W-1:0]  saturated;
    tavc_pkg::vel_t                     desired_next;
    tavc_pkg::vel_t                     desired_reg;

    logic signed [tavc_pkg::SLEW_W-1:0] delta;
    logic signed [tavc_pkg::SLEW_W-1:0] maxd_wide;
    logic signed [tavc_pkg::SLEW_W-1:0] step_up;
    logic signed [tavc_pkg::SLEW_W-1:0] step_dn;
    tavc_pkg::vel_t                     held_next;
    tavc_pkg::vel_t                     held_reg;

    // stage 1: operand sum and both products
    assign pos_stab_next = tavc_pkg::PS_W'(pos) + tavc_pkg::PS_W'(stab);
    assign ff_prod_next  = ff * $signed(cfg.gain);
    assign acc_prod      = tavc_pkg::ACC_W'(cfg.amax) * tavc_pkg::ACC_W'(tick);
    assign maxd_next     = acc_prod[tavc_pkg::ACC_W-1:tavc_pkg::DT_FRAC_BITS];

    // stage 2: velocity clamp, round half up, range saturation
    assign sum        = (tavc_pkg::SUM_W'(pos_stab_reg) <<< 8) + tavc_pkg::SUM_W'(ff_prod_reg);
    assign lim_scaled = signed'({{(tavc_pkg::SUM_W - tavc_pkg::LIMIT_W - 8){1'b0}},
                                 cfg.vmax, 8'h00});
    assign lim_wide   = signed'({{(tavc_pkg::SUM_W - tavc_pkg::LIMIT_W){1'b0}}, cfg.vmax});
    assign rnd        = (sum + tavc_pkg::SUM_W'(128)) >>> 8;
    assign vtop       = signed'({{(tavc_pkg::SUM_W - tavc_pkg::VELOCITY_BITS + 1){1'b0}},
                                 {(tavc_pkg::VELOCITY_BITS - 1){1'b1}}});
    assign vbot       = ~vtop;

    always_comb
    begin
        if (sum > lim_scaled)
        begin
            clamped = lim_wide;
        end
        else if (sum < -lim_scaled)
        begin
            clamped = -lim_wide;
        end
        else
        begin
            clamped = rnd;
        end

        if (clamped > vtop)
        begin
            saturated = vtop;
        end
        else if (clamped < vbot)
        begin
            saturated = vbot;
        end
        else
        begin
            saturated = clamped;
        end
    end

    assign desired_next = saturated[tavc_pkg::VELOCITY_BITS-1:0];

    // stage 3: slew limit against the held value
    assign delta     = tavc_pkg::SLEW_W'(desired_reg) - tavc_pkg::SLEW_W'(held_reg);
    assign maxd_wide = signed'({{(tavc_pkg::SLEW_W - tavc_pkg::MAXD_W){1'b0}}, maxd2_reg});
    assign step_up   = tavc_pkg::SLEW_W'(held_reg) + maxd_wide;
    assign step_dn   = tavc_pkg::SLEW_W'(held_reg) - maxd_wide;

    always_comb
    begin
        if (delta > maxd_wide)
        begin
            held_next = step_up[tavc_pkg::VELOCITY_BITS-1:0];
        end
        else if (delta < -maxd_wide)
        begin
            held_next = step_dn[tavc_pkg::VELOCITY_BITS-1:0];
        end
        else
        begin
            held_next = desired_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld1)
        begin
            pos_stab_reg <= pos_stab_next;
            ff_prod_reg  <= ff_prod_next;
            maxd1_reg    <= maxd_next;
        end
        if (ctrl.ld2)
        begin
            desired_reg <= desired_next;
            maxd2_reg   <= maxd1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else if (ctrl.upd)
        begin
            held_reg <= held_next;
        end
    end

    assign held = held_reg;

endmodule

### sv/two_axis_velocity_combiner_unit.sv
`timescale 1ns / 1ps

// Pan/tilt velocity combiner with clamp and slew limit. Each input beat yields
// one output beat; beats can be accepted every cycle unless the full pipeline
// stalls: two axis lanes run a three-stage pipeline (operand sum and
// multiplies, velocity clamp and rounding, slew step against the held
// velocity), and the last stage's held velocity register is also the output
// data register. A beat whose tick period is zero or above 20971 leaves the
// held velocities unchanged, repeats them and sets tuser. The user must write
// configuration through the APB port only with no beat in flight; unenforced.

module two_axis_velocity_combiner_unit
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // position_vel_pan, position_vel_tilt, stabilize_vel_pan,
    // stabilize_vel_tilt, feedfwd_vel_pan, feedfwd_vel_tilt, tick_period
    input  logic [tavc_pkg::IN_W-1:0]     s_axis_tdata,

    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // command_vel_pan, command_vel_tilt
    output logic [tavc_pkg::OUT_W-1:0]    m_axis_tdata,
    // step_rejected
    output logic [0:0]                    m_axis_tuser,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tavc_pkg::ADDR_W-1:0]   paddr,
    input  logic [tavc_pkg::DATA_W-1:0]   pwdata,
    output logic [tavc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    tavc_pkg::lane_cfg_t         cfg_pan;
    tavc_pkg::lane_cfg_t         cfg_tilt;
    tavc_pkg::lane_ctrl_t        ctrl;
    tavc_pkg::vel_t              held_pan;
    tavc_pkg::vel_t              held_tilt;
    logic [tavc_pkg::TICK_W-1:0] tick;

    logic v1_reg;
    logic v2_reg;
    logic out_valid_reg;
    logic rej1_reg;
    logic rej2_reg;
    logic rej_out_reg;
    logic rej_next;
    logic ld1;
    logic ld2;
    logic ld3;

    assign tick = s_axis_tdata[6*tavc_pkg::VELOCITY_BITS +: tavc_pkg::TICK_W];

    tavc_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .cfg_pan  (cfg_pan),
        .cfg_tilt (cfg_tilt)
    );

    tavc_lane u_lane_pan
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .cfg   (cfg_pan),
        .pos   (s_axis_tdata[0*tavc_pkg::VELOCITY_BITS +: tavc_pkg::VELOCITY_BITS]),
        .stab  (s_axis_tdata[2*tavc_pkg::VELOCITY_BITS +: tavc_pkg::VELOCITY_BITS]),
        .ff    (s_axis_tdata[4*tavc_pkg::VELOCITY_BITS +: tavc_pkg::VELOCITY_BITS]),
        .tick  (tick),
        .held  (held_pan)
    );

    tavc_lane u_lane_tilt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .cfg   (cfg_tilt),
        .pos   (s_axis_tdata[1*tavc_pkg::VELOCITY_BITS +: tavc_pkg::VELOCITY_BITS]),
        .stab  (s_axis_tdata[3*tavc_pkg::VELOCITY_BITS +: tavc_pkg::VELOCITY_BITS]),
        .ff    (s_axis_tdata[5*tavc_pkg::VELOCITY_BITS +: tavc_pkg::VELOCITY_BITS]),
        .tick  (tick),
        .held  (held_tilt)
    );

    // advance each stage when the one after it is empty or moving
    assign ld3 = !out_valid_reg || m_axis_tready;
    assign ld2 = !v2_reg || ld3;
    assign ld1 = !v1_reg || ld2;

    assign ctrl.ld1 = ld1;
    assign ctrl.ld2 = ld2;
    assign ctrl.upd = ld3 && v2_reg && !rej2_reg;

    assign rej_next = (tick == '0) || (tick > tavc_pkg::TICK_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            rej1_reg      <= 1'b0;
            rej2_reg      <= 1'b0;
            rej_out_reg   <= 1'b0;
        end
        else
        begin
            if (ld1)
            begin
                v1_reg   <= s_axis_tvalid;
                rej1_reg <= rej_next;
            end
            if (ld2)
            begin
                v2_reg   <= v1_reg;
                rej2_reg <= rej1_reg;
            end
            if (ld3)
            begin
                out_valid_reg <= v2_reg;
                if (v2_reg)
                begin
                    rej_out_reg <= rej2_reg;
                end
            end
        end
    end

    assign s_axis_tready   = ld1;
    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = tavc_pkg::OUT_W'({held_tilt, held_pan});
    assign m_axis_tuser[0] = rej_out_reg;

    a_hold_on_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (ld3 && v2_reg && rej2_reg) |=> ($stable(held_pan) && $stable(held_tilt)))
        else $error("held velocity changed on a rejected beat");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted into a full, stalled pipeline");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!v1_reg && !v2_reg && !out_valid_reg) |-> s_axis_tready)
        else $error("empty pipeline refused an input beat");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(v2_reg))
        else $error("output beat appeared without a beat in stage two");

endmodule
